FILE: sv/hse_pkg.sv
// Shared types and codes for the Hermite spline evaluator.
// Holds the transaction payload structs, function codes and register indexes.
// No dependencies.
`default_nettype none

package hse_pkg;

	localparam int VAL_W   = 16;
	localparam int IDX_W   = 6;
	localparam int PHASE_W = 20;

	// function codes carried in the input transaction
	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_EVAL    = 2'd1;
	localparam logic [1:0] FUNC_TANGENT = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LOOP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT  = 1'b1;

	typedef struct packed {
		logic [1:0]              func;
		logic [IDX_W-1:0]        knot_index;
		logic signed [VAL_W-1:0] knot_value;
		logic signed [VAL_W-1:0] knot_tangent;
		logic [PHASE_W-1:0]      phase;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] curve_value;
		logic                    status;
	} out_item_t;

	// write enables of the knot store, one per array
	typedef struct packed {
		logic val;
		logic tan;
	} knot_we_t;

endpackage

`default_nettype wire

FILE: sv/hse_knot_mem.sv
// Knot store: value and tangent arrays, one write and one registered read port.
// Depends on hse_pkg for the write-enable struct and the value width.
`default_nettype none

module hse_knot_mem #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire                                 clk,
	input  hse_pkg::knot_we_t                   we,
	input  wire  [AW-1:0]                       waddr,
	input  wire  signed [hse_pkg::VAL_W-1:0]    wval,
	input  wire  signed [hse_pkg::VAL_W-1:0]    wtan,
	input  wire  [AW-1:0]                       raddr,
	output logic signed [hse_pkg::VAL_W-1:0]    rval,
	output logic signed [hse_pkg::VAL_W-1:0]    rtan
);

	logic signed [hse_pkg::VAL_W-1:0] val_mem [DEPTH];
	logic signed [hse_pkg::VAL_W-1:0] tan_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.val) begin
			val_mem[waddr] <= wval;
		end
		if (we.tan) begin
			tan_mem[waddr] <= wtan;
		end
		rval <= val_mem[raddr];
		rtan <= tan_mem[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/hermite_spline_evaluator.sv
// Cubic Hermite spline evaluator: knot store, evaluation datapath, tangent pass.
// Depends on hse_pkg (payload structs, codes) and hse_knot_mem (knot store).
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one transaction per item:
//   write knot, evaluate at phase, or attach Catmull-Rom tangents. Every input
//   transaction yields exactly one output transaction on out_valid/out_ready/
//   out_data (curve_value is zero for all but evaluate; status flags a knot
//   write at or beyond the knot count, which is then dropped).
//   Configuration goes through cfg_wr_en/cfg_index/cfg_data while idle.
//   One item is worked at a time; a result waits in the output register while
//   the next item is taken. Evaluation runs a chain of multiplies and a single
//   multiply-accumulate over the four basis terms; the tangent pass is bound by
//   the one read port of the value array, one knot per cycle.
//   Reset clears configuration (open mode, two knots) and control state; knot
//   contents are undefined until written, no clearing pass runs.
//   When the receiver stalls, a finished result holds in DONE until the
//   output register frees.
`default_nettype none

module hermite_spline_evaluator #(
	parameter int MAX_KNOTS = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  hse_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output hse_pkg::out_item_t                    out_data,
	input  wire                                   cfg_wr_en,
	input  wire  [hse_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [hse_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int AW = $clog2(MAX_KNOTS);
	localparam int CW = $clog2(MAX_KNOTS + 1);
	localparam int XW = (CW > hse_pkg::CFG_DATA_W) ? CW : hse_pkg::CFG_DATA_W;
	localparam int RW = CW + 1;
	localparam int IW = (AW > hse_pkg::IDX_W) ? AW : hse_pkg::IDX_W;
	localparam int SW = 17 + CW;
	localparam int VW = hse_pkg::VAL_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_WRITE   = 4'd1;
	localparam logic [3:0] ST_E_SEG   = 4'd2;
	localparam logic [3:0] ST_E_SQ    = 4'd3;
	localparam logic [3:0] ST_E_CUBE  = 4'd4;
	localparam logic [3:0] ST_E_BAS1  = 4'd5;
	localparam logic [3:0] ST_E_BAS2  = 4'd6;
	localparam logic [3:0] ST_E_MAC   = 4'd7;
	localparam logic [3:0] ST_T_RUN   = 4'd8;
	localparam logic [3:0] ST_T_DRAIN = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	// Index into the knot table, folded to [0, cnt) for a non-negative index.
	function automatic logic [AW-1:0] resolve_up(input logic [RW-1:0] idx,
			input logic [CW-1:0] cnt, input logic closed);
		logic [RW-1:0] c;
		logic [RW-1:0] r;
		c = RW'(cnt);
		r = idx;
		if (idx >= c) begin
			r = closed ? idx - c : c - RW'(1);
		end
		if (r >= c) begin
			r = c - RW'(1);
		end
		return r[AW-1:0];
	endfunction

	// Round a Q1.48 basis value to Q1.16.
	function automatic logic [16:0] round_q16(input logic [49:0] x);
		logic [49:0] y;
		y = x + (50'(1) << 31);
		return y[48:32];
	endfunction

	// control
	logic [3:0]                  state_q;
	logic                        closed_q;
	logic [hse_pkg::CFG_DATA_W-1:0] kcount_q;
	logic [1:0]                  mac_q;
	logic [RW-1:0]               r_q;
	logic                        rv_s1;
	logic                        out_valid_q;

	// datapath
	logic [hse_pkg::IDX_W-1:0]   wr_idx_q;
	logic signed [VW-1:0]        wr_val_q;
	logic signed [VW-1:0]        wr_tan_q;
	logic                        status_q;
	logic [16:0]                 t_q;
	logic [SW-1:0]               s_q;
	logic [15:0]                 u_q;
	logic [31:0]                 u2_q;
	logic [47:0]                 b_q;
	logic [AW-1:0]               i1_q;
	logic signed [VW-1:0]        v0_q, m0_q, v1_q, m1_q;
	logic [49:0]                 p_q, q_q;
	logic [16:0]                 h00_q, h01_q, h10_q, h11n_q;
	logic signed [35:0]          acc_q;
	logic [RW-1:0]               ridx_s1;
	logic signed [VW-1:0]        w0_q, w1_q;
	hse_pkg::out_item_t          out_q;

	// combinational
	logic                        in_fire;
	logic                        out_free;
	logic [XW-1:0]               kc_x, eff_x;
	logic [CW-1:0]               eff_cnt;
	logic [CW-1:0]               n_cnt;
	logic [IW-1:0]               wr_idx_x;
	logic                        wr_ok;
	logic [16:0]                 t_open, t_fold, t_next;
	logic [RW-1:0]               seg;
	logic [47:0]                 a_w, tt_w;
	logic [16:0]                 hs;
	logic signed [17:0]          hs_s;
	logic signed [VW-1:0]        xs;
	logic signed [33:0]          prod;
	logic signed [35:0]          rsum, rsh;
	logic signed [VW-1:0]        rsat;
	logic [RW-1:0]               last_rd;
	logic [RW-1:0]               pass_addr;
	logic [RW-1:0]               tan_waddr_x;
	logic                        tan_we;
	logic signed [16:0]          diff;
	logic signed [16:0]          half;
	hse_pkg::knot_we_t           mem_we;
	logic [AW-1:0]               mem_waddr;
	logic signed [VW-1:0]        mem_wtan;
	logic [AW-1:0]               mem_raddr;
	logic signed [VW-1:0]        mem_rval, mem_rtan;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// effective knot count and segment count
	assign kc_x    = XW'(kcount_q);
	assign eff_x   = (kc_x < XW'(2)) ? XW'(2) :
	                 (kc_x > XW'(MAX_KNOTS)) ? XW'(MAX_KNOTS) : kc_x;
	assign eff_cnt = CW'(eff_x);
	assign n_cnt   = closed_q ? eff_cnt : eff_cnt - CW'(1);

	assign wr_idx_x = IW'(wr_idx_q);
	assign wr_ok    = XW'(wr_idx_q) < eff_x;

	// phase reduction: fold over a period of two when open
	assign t_open = in_data.phase[16:0];
	assign t_fold = (t_open > 17'd65536) ? 17'(18'd131072 - {1'b0, t_open}) : t_open;
	assign t_next = closed_q ? {1'b0, in_data.phase[15:0]} : t_fold;

	assign seg  = s_q[SW-1:16];
	assign a_w  = {u2_q, 16'b0};
	assign tt_w = {u_q, 32'b0};

	// basis term select for the shared multiply-accumulate
	always_comb begin
		case (mac_q)
			2'd0: begin hs = h00_q;  xs = v0_q; end
			2'd1: begin hs = h10_q;  xs = m0_q; end
			2'd2: begin hs = h01_q;  xs = v1_q; end
			default: begin hs = h11n_q; xs = m1_q; end
		endcase
	end
	assign hs_s = {1'b0, hs};
	assign prod = hs_s * xs;

	// round to Q8.8 and saturate
	assign rsum = acc_q + 36'sd32768;
	assign rsh  = rsum >>> 16;
	assign rsat = (rsh > 36'sd32767) ? 16'sh7fff :
	              (rsh < -36'sd32768) ? 16'sh8000 : rsh[VW-1:0];

	// tangent pass: read stream prev, k.., next; wrap at the ends when closed, inner knots only when open
	assign last_rd = closed_q ? RW'(eff_cnt) + RW'(1) : RW'(eff_cnt) - RW'(1);
	always_comb begin
		if (!closed_q) begin
			pass_addr = r_q;
		end else if (r_q == '0) begin
			pass_addr = RW'(eff_cnt) - RW'(1);
		end else if (r_q == last_rd) begin
			pass_addr = '0;
		end else begin
			pass_addr = r_q - RW'(1);
		end
	end

	assign tan_we      = rv_s1 && (ridx_s1 >= RW'(2));
	assign tan_waddr_x = closed_q ? ridx_s1 - RW'(2) : ridx_s1 - RW'(1);
	assign diff        = 17'(mem_rval) - 17'(w0_q);
	assign half        = diff >>> 1;

	// knot store port muxing
	always_comb begin
		mem_we.val = (state_q == ST_WRITE) && wr_ok;
		mem_we.tan = ((state_q == ST_WRITE) && wr_ok) || tan_we;
		if (state_q == ST_WRITE) begin
			mem_waddr = wr_idx_x[AW-1:0];
			mem_wtan  = wr_tan_q;
		end else begin
			mem_waddr = tan_waddr_x[AW-1:0];
			mem_wtan  = half[VW-1:0];
		end
		case (state_q)
			ST_E_SQ:   mem_raddr = resolve_up(seg, eff_cnt, closed_q);
			ST_E_CUBE: mem_raddr = i1_q;
			ST_T_RUN:  mem_raddr = pass_addr[AW-1:0];
			default:   mem_raddr = '0;
		endcase
	end

	hse_knot_mem #(
		.DEPTH (MAX_KNOTS)
	) u_knot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wval  (wr_val_q),
		.wtan  (mem_wtan),
		.raddr (mem_raddr),
		.rval  (mem_rval),
		.rtan  (mem_rtan)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			kcount_q <= hse_pkg::CFG_DATA_W'(2);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				hse_pkg::CFG_CLOSED_LOOP: closed_q <= cfg_data[0];
				hse_pkg::CFG_KNOT_COUNT:  kcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mac_q       <= '0;
			r_q         <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_T_RUN);
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						r_q <= '0;
						case (in_data.func)
							hse_pkg::FUNC_WRITE: state_q <= ST_WRITE;
							hse_pkg::FUNC_EVAL:  state_q <= ST_E_SEG;
							hse_pkg::FUNC_TANGENT: begin
								// open spline with two knots has no inner knot
								if (!closed_q && eff_cnt == CW'(2)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_T_RUN;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_WRITE:  state_q <= ST_DONE;
				ST_E_SEG:  state_q <= ST_E_SQ;
				ST_E_SQ:   state_q <= ST_E_CUBE;
				ST_E_CUBE: state_q <= ST_E_BAS1;
				ST_E_BAS1: state_q <= ST_E_BAS2;
				ST_E_BAS2: begin
					mac_q   <= '0;
					state_q <= ST_E_MAC;
				end
				ST_E_MAC: begin
					mac_q <= mac_q + 2'd1;
					if (mac_q == 2'd3) begin
						state_q <= ST_DONE;
					end
				end
				ST_T_RUN: begin
					r_q <= r_q + RW'(1);
					if (r_q == last_rd) begin
						state_q <= ST_T_DRAIN;
					end
				end
				ST_T_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			wr_idx_q <= in_data.knot_index;
			wr_val_q <= in_data.knot_value;
			wr_tan_q <= in_data.knot_tangent;
			t_q      <= t_next;
			acc_q    <= '0;
			status_q <= 1'b0;
		end
		if (state_q == ST_WRITE) begin
			status_q <= !wr_ok;
		end
		if (state_q == ST_E_SEG) begin
			s_q <= SW'(t_q) * SW'(n_cnt);
		end
		if (state_q == ST_E_SQ) begin
			u_q  <= s_q[15:0];
			u2_q <= 32'(s_q[15:0]) * 32'(s_q[15:0]);
			i1_q <= resolve_up(seg + RW'(1), eff_cnt, closed_q);
		end
		if (state_q == ST_E_CUBE) begin
			v0_q <= mem_rval;
			m0_q <= mem_rtan;
			b_q  <= 48'(u2_q) * 48'(u_q);
		end
		if (state_q == ST_E_BAS1) begin
			v1_q <= mem_rval;
			m1_q <= mem_rtan;
			// p = 3t^2 - 2t^3, q = t^2 - t^3
			p_q  <= (50'(a_w) << 1) + 50'(a_w) - (50'(b_q) << 1);
			q_q  <= 50'(a_w) - 50'(b_q);
		end
		if (state_q == ST_E_BAS2) begin
			h01_q  <= round_q16(p_q);
			h11n_q <= round_q16(q_q);
			h00_q  <= round_q16((50'(1) << 48) - p_q);
			h10_q  <= round_q16(50'(tt_w) - 50'(a_w) - q_q);
		end
		if (state_q == ST_E_MAC) begin
			if (mac_q == 2'd3) begin
				acc_q <= acc_q - 36'(prod);
			end else begin
				acc_q <= acc_q + 36'(prod);
			end
		end
		// slide the value window of the tangent pass
		ridx_s1 <= r_q;
		if (rv_s1) begin
			w0_q <= w1_q;
			w1_q <= mem_rval;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.curve_value <= rsat;
			out_q.status      <= status_q;
		end
	end

	// checks
	a_tan_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tan_we |-> (tan_waddr_x < RW'(eff_cnt)))
		else $error("tangent write beyond knot count");

	a_pass_pipe_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_T_RUN || state_q == ST_T_DRAIN))
		else $error("tangent read pipeline active outside the pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second transaction taken while one is in flight");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not loaded into free output register");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for hermite_spline_evaluator: knot writes, evaluations,
// Catmull-Rom passes and unknown codes, checked against an in-bench spline predictor.
// Depends on hse_pkg and the hermite_spline_evaluator RTL.
`default_nettype none

module tb;

	localparam int MAX_KNOTS = 64;
	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hse_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hse_pkg::out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [hse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic mdl_closed = 1'b0;
	logic [6:0] mdl_count = 7'd2;
	logic signed [hse_pkg::VAL_W-1:0] mdl_val [MAX_KNOTS];
	logic signed [hse_pkg::VAL_W-1:0] mdl_tan [MAX_KNOTS];

	hse_pkg::in_item_t todo_items [$];
	hse_pkg::out_item_t awaited_results [$];
	hse_pkg::out_item_t want;
	int errors = 0;
	int results_seen = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int window_left = 0;
	int stall_mode = 0;
	int stall_cycles = 0;

	hermite_spline_evaluator #(.MAX_KNOTS(MAX_KNOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_knots();
		int c;
		c = int'(mdl_count);
		if (c < 2) c = 2;
		if (c > MAX_KNOTS) c = MAX_KNOTS;
		return c;
	endfunction

	// clamp in open mode, wrap in closed mode
	function automatic int resolve_knot(int idx, int cnt);
		if (idx < 0)
			idx = mdl_closed ? idx + cnt : 0;
		else if (idx >= cnt)
			idx = mdl_closed ? idx - cnt : cnt - 1;
		if (idx < 0) idx = 0;
		if (idx >= cnt) idx = cnt - 1;
		return idx;
	endfunction

	function automatic logic signed [hse_pkg::VAL_W-1:0] blend_at(
			logic [hse_pkg::PHASE_W-1:0] ph);
		longint unsigned t, n, s, u, sq, cu, lin, half;
		longint h00, h01, h10, h11n, acc, r;
		int cnt, seg, i0, i1;
		cnt = eff_knots();
		if (mdl_closed) begin
			t = ph[15:0];
		end else begin
			t = ph[16:0];
			if (t > 64'd65536) t = 64'd131072 - t;
		end
		n = mdl_closed ? cnt : cnt - 1;
		s = t * n;
		seg = int'(s >> 16);
		u = s & 64'hFFFF;
		// basis terms in Q1.48, each rounded to Q1.16
		sq = (u * u) << 16;
		cu = u * u * u;
		lin = u << 32;
		half = 64'd1 << 31;
		h00 = longint'(((64'd1 << 48) + 2 * cu - 3 * sq + half) >> 32);
		h01 = longint'((3 * sq - 2 * cu + half) >> 32);
		h10 = longint'((lin + cu - 2 * sq + half) >> 32);
		h11n = longint'((sq - cu + half) >> 32);
		i0 = resolve_knot(seg, cnt);
		i1 = resolve_knot(seg + 1, cnt);
		acc = h00 * mdl_val[i0] + h10 * mdl_tan[i0] + h01 * mdl_val[i1]
			- h11n * mdl_tan[i1];
		r = (acc + 32768) >>> 16;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic void catmull_pass();
		int cnt, first, k, diff, half_diff;
		cnt = eff_knots();
		first = mdl_closed ? 0 : 1;
		for (k = first; k < cnt - first; k++) begin
			diff = int'(mdl_val[resolve_knot(k + 1, cnt)])
				- int'(mdl_val[resolve_knot(k - 1, cnt)]);
			half_diff = diff >>> 1;
			mdl_tan[resolve_knot(k, cnt)] = half_diff[15:0];
		end
	endfunction

	function automatic hse_pkg::out_item_t spline_step(hse_pkg::in_item_t it);
		hse_pkg::out_item_t res;
		res = '0;
		case (it.func)
			hse_pkg::FUNC_WRITE: begin
				if (int'(it.knot_index) < eff_knots()) begin
					mdl_val[it.knot_index] = it.knot_value;
					mdl_tan[it.knot_index] = it.knot_tangent;
				end else begin
					res.status = 1'b1;
				end
			end
			hse_pkg::FUNC_EVAL: res.curve_value = blend_at(it.phase);
			hse_pkg::FUNC_TANGENT: catmull_pass();
			default: ;
		endcase
		return res;
	endfunction

	function automatic hse_pkg::in_item_t make_item(logic [1:0] f, int idx, int v, int tg,
			int ph);
		hse_pkg::in_item_t it;
		it.func = f;
		it.knot_index = idx[hse_pkg::IDX_W-1:0];
		it.knot_value = v[hse_pkg::VAL_W-1:0];
		it.knot_tangent = tg[hse_pkg::VAL_W-1:0];
		it.phase = ph[hse_pkg::PHASE_W-1:0];
		return it;
	endfunction

	function automatic hse_pkg::in_item_t random_item();
		hse_pkg::in_item_t it;
		int pick;
		int rnd;
		rnd = $urandom_range(0, 63);
		it.knot_index = rnd[hse_pkg::IDX_W-1:0];
		rnd = $urandom_range(0, 65535);
		it.knot_value = rnd[hse_pkg::VAL_W-1:0];
		rnd = $urandom_range(0, 65535);
		it.knot_tangent = rnd[hse_pkg::VAL_W-1:0];
		rnd = $urandom_range(0, 20'hFFFFF);
		it.phase = rnd[hse_pkg::PHASE_W-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.func = hse_pkg::FUNC_WRITE;
			if ($urandom_range(0, 9) < 6) begin
				rnd = $urandom_range(0, eff_knots() - 1);
				it.knot_index = rnd[hse_pkg::IDX_W-1:0];
			end
		end else if (pick < 85) begin
			it.func = hse_pkg::FUNC_EVAL;
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 5))
					0: it.phase = 20'h00000;
					1: it.phase = 20'h0FFFF;
					2: it.phase = 20'h10000;
					3: it.phase = 20'h10001;
					4: it.phase = 20'h1FFFF;
					default: it.phase = 20'hFFFFF;
				endcase
			end
		end else if (pick < 93) begin
			it.func = hse_pkg::FUNC_TANGENT;
		end else begin
			it.func = FUNC_UNKNOWN;
		end
		return it;
	endfunction

	// sample at the falling edge so all updates of the rising edge have landed
	task automatic wait_idle();
		do
			@(negedge clk);
		while (todo_items.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [hse_pkg::CFG_IDX_W-1:0] idx,
			logic [hse_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_setting(logic cl, logic [6:0] cnt);
		wait_idle();
		write_reg(hse_pkg::CFG_CLOSED_LOOP, {{(hse_pkg::CFG_DATA_W-1){1'b0}}, cl});
		write_reg(hse_pkg::CFG_KNOT_COUNT, cnt);
		mdl_closed = cl;
		mdl_count = cnt;
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				awaited_results.push_back(spline_step(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || todo_items.size() == 0) begin
					if (gap_left > 0) gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else begin
					in_data <= todo_items.pop_front();
					in_valid <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// monitor: check results and drive the receiver's stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got value %0d status %0d",
						$time, out_data.curve_value, out_data.status);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (out_data.curve_value !== want.curve_value) begin
						$display("%0t: curve_value mismatch, expected %0d, got %0d",
							$time, want.curve_value, out_data.curve_value);
						errors++;
					end
					if (out_data.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, out_data.status);
						errors++;
					end
				end
				results_seen++;
				// hold off long enough for the block to back up into its input
				if (results_seen == 300 || results_seen == 1200)
					hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (window_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					window_left = $urandom_range(16, 96);
				end
				window_left = window_left - 1;
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int ph, k, cnt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// fill every knot first so no evaluation or pass reads an unwritten entry
		apply_setting(1'b0, 7'd64);
		for (k = 0; k < MAX_KNOTS; k++)
			todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, k, $urandom, $urandom, 0));

		// extreme knots at both ends of the table drive the result into saturation
		todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, 0, 32767, 32767, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, 1, 32767, -32768, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, 62, -32768, -32768, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, 63, -32768, 32767, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 520));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 65016));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h00000));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h10000));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h18000));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h1FFFF));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h20000));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 63, -1, -1, 'hFFFFF));
		todo_items.push_back(make_item(FUNC_UNKNOWN, 63, -1, -1, 'hFFFFF));
		todo_items.push_back(make_item(hse_pkg::FUNC_TANGENT, 0, 0, 0, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 520));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 65016));
		todo_items.push_back(make_item(hse_pkg::FUNC_WRITE, 32, 0, 0, 0));
		todo_items.push_back(make_item(hse_pkg::FUNC_EVAL, 0, 0, 0, 'h08000));

		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: cnt = 64;
				1: cnt = 2;
				2: cnt = 2;
				3: cnt = 0;
				4: cnt = 1;
				5: cnt = 127;
				6: cnt = 65;
				9: cnt = 64;
				default: cnt = $urandom_range(3, 63);
			endcase
			apply_setting((ph % 2) == 0, cnt[6:0]);
			for (k = 0; k < 170; k++)
				todo_items.push_back(random_item());
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
